@@ sv/rotation_matrix_to_quaternion_assert.svh @@
// assertion macros shared by the rotation matrix to quaternion rtl
// expects i_clk and i_rst_n in the module that uses them
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// condition must never hold
`define RMQ_ASSERT_NEVER(name, expr) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("rmq: assertion failed");

// consequence in the same cycle
`define RMQ_ASSERT_SAME(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("rmq: assertion failed");

// consequence in the next cycle
`define RMQ_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("rmq: assertion failed");

`endif

@@ sv/rmq_pkg.sv @@
// shared constants, types and width helpers for the matrix to quaternion block
// no dependencies
`default_nettype none

package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int ENTRY_W       = 16;
    localparam int NUM_W         = 17;
    localparam int Q_DEPTH       = 4;

    // branch codes
    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    typedef struct packed {
        logic [1:0] branch;
        logic       bad;
    } t_meta;

    // signed width of the root argument
    function automatic int f_arg_w(input int frac);
        return ((frac > ENTRY_W + 1) ? frac : ENTRY_W + 1) + 3;
    endfunction

    // width of the integer square root
    function automatic int f_root_w(input int frac);
        return (f_arg_w(frac) - 1 + frac + 1) >> 1;
    endfunction

    // width of one queue word
    function automatic int f_item_w(input int frac);
        return f_arg_w(frac) - 1 + 3 * NUM_W + 3;
    endfunction

endpackage

`default_nettype wire

@@ sv/rmq_front.sv @@
// front end: picks the branch, forms the root argument and the three numerators
// depends on rmq_pkg
`default_nettype none

module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic signed [rmq_pkg::ENTRY_W-1:0]       i_e00,
    input  logic signed [rmq_pkg::ENTRY_W-1:0]       i_e01,
    input  logic signed [rmq_pkg::ENTRY_W-1:0]       i_e02,
    input  logic signed [rmq_pkg::ENTRY_W-1:0]       i_e10,
    input  logic signed [rmq_pkg::ENTRY_W-1:0]       i_e11,
    input  logic signed [rmq_pkg::ENTRY_W-1:0]       i_e12,
    input  logic signed [rmq_pkg::ENTRY_W-1:0]       i_e20,
    input  logic signed [rmq_pkg::ENTRY_W-1:0]       i_e21,
    input  logic signed [rmq_pkg::ENTRY_W-1:0]       i_e22,
    output logic                                     o_item_valid,
    input  logic                                     i_item_ready,
    output logic [rmq_pkg::f_item_w(FRAC_BITS)-1:0]  o_item
);
    import rmq_pkg::*;

    localparam int AW = f_arg_w(FRAC_BITS);
    localparam int IW = f_item_w(FRAC_BITS);

    logic signed [AW-1:0]    w_a00, w_a11, w_a22, w_one, w_trace, w_arg;
    logic signed [NUM_W-1:0] w_n0, w_n1, w_n2;
    t_meta                   w_meta;
    logic [IW-1:0]           n_item;
    logic [IW-1:0]           r_item;
    logic                    r_valid;

    // diagonal sign extended to argument width
    assign w_a00   = AW'(i_e00);
    assign w_a11   = AW'(i_e11);
    assign w_a22   = AW'(i_e22);
    assign w_one   = {{(AW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    assign w_trace = w_a00 + w_a11 + w_a22;

    // branch select and numerators in output order of the back end
    always_comb begin
        if (!w_trace[AW-1] && (w_trace != '0)) begin
            w_meta.branch = BR_TRACE;
            w_arg = w_one + w_trace;
            w_n0  = NUM_W'(i_e21) - NUM_W'(i_e12);
            w_n1  = NUM_W'(i_e02) - NUM_W'(i_e20);
            w_n2  = NUM_W'(i_e10) - NUM_W'(i_e01);
        end else if ((i_e00 > i_e11) && (i_e00 > i_e22)) begin
            w_meta.branch = BR_X;
            w_arg = w_one + w_a00 - w_a11 - w_a22;
            w_n0  = NUM_W'(i_e01) + NUM_W'(i_e10);
            w_n1  = NUM_W'(i_e20) + NUM_W'(i_e02);
            w_n2  = NUM_W'(i_e21) - NUM_W'(i_e12);
        end else if (i_e11 > i_e22) begin
            w_meta.branch = BR_Y;
            w_arg = w_one + w_a11 - w_a00 - w_a22;
            w_n0  = NUM_W'(i_e01) + NUM_W'(i_e10);
            w_n1  = NUM_W'(i_e12) + NUM_W'(i_e21);
            w_n2  = NUM_W'(i_e02) - NUM_W'(i_e20);
        end else begin
            w_meta.branch = BR_Z;
            w_arg = w_one + w_a22 - w_a00 - w_a11;
            w_n0  = NUM_W'(i_e02) + NUM_W'(i_e20);
            w_n1  = NUM_W'(i_e12) + NUM_W'(i_e21);
            w_n2  = NUM_W'(i_e10) - NUM_W'(i_e01);
        end
        w_meta.bad = w_arg[AW-1] || (w_arg == '0);
    end

    assign n_item = {w_arg[AW-2:0], w_n0, w_n1, w_n2, w_meta};

    // one register stage toward the queue
    assign o_ready      = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

@@ sv/rmq_queue.sv @@
// small word queue between the front end and the arithmetic back end
// depends on rmq_pkg and the assertion header
`default_nettype none
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rmq_pkg::Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    import rmq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [PW:0]      r_count;
    logic             w_push, w_pop;

    assign o_ready = (r_count != (PW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    // word storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `RMQ_ASSERT_NEVER(a_count_bound, r_count > (PW+1)'(DEPTH))
    `RMQ_ASSERT_NEXT(a_full_stays, !o_ready && !i_ready, !o_ready)

endmodule

`default_nettype wire

@@ sv/rmq_back.sv @@
// back end: pipelined square root, three pipelined dividers, rounding and output register
// depends on rmq_pkg and the assertion header
`default_nettype none
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_back #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [rmq_pkg::f_item_w(FRAC_BITS)-1:0] i_item,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [rmq_pkg::ENTRY_W-1:0]             o_quat_w,
    output logic [rmq_pkg::ENTRY_W-1:0]             o_quat_x,
    output logic [rmq_pkg::ENTRY_W-1:0]             o_quat_y,
    output logic [rmq_pkg::ENTRY_W-1:0]             o_quat_z,
    output logic [1:0]                              o_branch_taken,
    output logic                                    o_invalid
);
    import rmq_pkg::*;

    localparam int AW = f_arg_w(FRAC_BITS);
    localparam int AB = AW - 1;
    localparam int IW = f_item_w(FRAC_BITS);
    localparam int SW = f_root_w(FRAC_BITS);
    localparam int NB = 2 * SW;
    localparam int QW = FRAC_BITS + 2;
    localparam int NW = NUM_W + FRAC_BITS + 1;
    localparam int HW = NW - QW;
    localparam int CW = (HW > SW + 1) ? HW : SW + 1;
    localparam int VW = (FRAC_BITS + 2 > ENTRY_W) ? FRAC_BITS + 2 : ENTRY_W;

    logic w_en;
    logic r_o_valid;

    // whole pipeline moves unless the output word is held
    assign w_en    = !r_o_valid || i_ready;
    assign o_ready = w_en;

    // square root stages, one root bit each
    logic              r_sq_v    [SW];
    logic [SW+1:0]     r_sq_rem  [SW];
    logic [SW-1:0]     r_sq_root [SW];
    logic [NB-1:0]     r_sq_nb   [SW];
    logic [3*NUM_W-1:0] r_sq_num [SW];
    t_meta             r_sq_meta [SW];

    for (genvar k = 0; k < SW; k++) begin : g_sq
        logic               c_v;
        logic [SW+1:0]      c_rem;
        logic [SW-1:0]      c_root;
        logic [NB-1:0]      c_nb;
        logic [3*NUM_W-1:0] c_num;
        t_meta              c_meta;
        logic [SW+3:0]      c_rem2, c_trial, c_diff;
        logic               c_ge;

        if (k == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_rem  = '0;
            assign c_root = '0;
            assign c_nb   = NB'({i_item[IW-1 -: AB], {FRAC_BITS{1'b0}}});
            assign c_num  = i_item[3*NUM_W+2:3];
            assign c_meta = t_meta'(i_item[2:0]);
        end else begin : g_next
            assign c_v    = r_sq_v[k-1];
            assign c_rem  = r_sq_rem[k-1];
            assign c_root = r_sq_root[k-1];
            assign c_nb   = r_sq_nb[k-1];
            assign c_num  = r_sq_num[k-1];
            assign c_meta = r_sq_meta[k-1];
        end

        assign c_rem2  = {c_rem, c_nb[NB-1:NB-2]};
        assign c_trial = (SW+4)'({c_root, 2'b01});
        assign c_ge    = (c_rem2 >= c_trial);
        assign c_diff  = c_rem2 - c_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[k]  <= c_ge ? c_diff[SW+1:0] : c_rem2[SW+1:0];
                r_sq_root[k] <= {c_root[SW-2:0], c_ge};
                r_sq_nb[k]   <= {c_nb[NB-3:0], 2'b00};
                r_sq_num[k]  <= c_num;
                r_sq_meta[k] <= c_meta;
            end
        end
    end

    // divider setup: half root, divisor 2s, rounded numerators
    logic [SW-1:0]  w_s;
    logic [SW:0]    w_s1;
    logic [SW:0]    w_dv;
    logic [SW:0]    w_rem0 [3];
    logic [QW-1:0]  w_lo0  [3];
    logic [2:0]     w_ovf0, w_sgn0;

    assign w_s  = r_sq_root[SW-1];
    assign w_s1 = (SW+1)'(w_s) + (SW+1)'(1);
    assign w_dv = {w_s, 1'b0};

    always_comb begin
        logic signed [NUM_W-1:0] v_num;
        logic [NUM_W-1:0]        v_mag;
        logic [NW-1:0]           v_nm;
        logic [CW-1:0]           v_hi;
        for (int j = 0; j < 3; j++) begin
            v_num     = r_sq_num[SW-1][(2-j)*NUM_W +: NUM_W];
            v_mag     = v_num[NUM_W-1] ? NUM_W'(-v_num) : NUM_W'(v_num);
            v_nm      = NW'({v_mag, {FRAC_BITS{1'b0}}}) + NW'(w_s);
            v_hi      = CW'(v_nm[NW-1:QW]);
            w_sgn0[j] = v_num[NUM_W-1];
            w_ovf0[j] = (v_hi >= CW'(w_dv));
            w_rem0[j] = v_hi[SW:0];
            w_lo0[j]  = v_nm[QW-1:0];
        end
    end

    logic           r_pp_v;
    logic [SW:0]    r_pp_dv;
    logic [SW-1:0]  r_pp_half;
    t_meta          r_pp_meta;
    logic [SW:0]    r_pp_rem [3];
    logic [QW-1:0]  r_pp_lo  [3];
    logic [2:0]     r_pp_ovf, r_pp_sgn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_v <= 1'b0;
        end else if (w_en) begin
            r_pp_v <= r_sq_v[SW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pp_dv   <= w_dv;
            r_pp_half <= w_s1[SW:1];
            r_pp_meta <= r_sq_meta[SW-1];
            r_pp_rem  <= w_rem0;
            r_pp_lo   <= w_lo0;
            r_pp_ovf  <= w_ovf0;
            r_pp_sgn  <= w_sgn0;
        end
    end

    // restoring divide stages, one quotient bit per lane each
    logic           r_dv_v    [QW];
    logic [SW:0]    r_dv_dv   [QW];
    logic [SW-1:0]  r_dv_half [QW];
    t_meta          r_dv_meta [QW];
    logic [2:0]     r_dv_ovf  [QW];
    logic [2:0]     r_dv_sgn  [QW];
    logic [SW:0]    r_dv_rem  [QW][3];
    logic [QW-1:0]  r_dv_lo   [QW][3];

    for (genvar k = 0; k < QW; k++) begin : g_dv
        logic           c_v;
        logic [SW:0]    c_dv;
        logic [SW-1:0]  c_half;
        t_meta          c_meta;
        logic [2:0]     c_ovf, c_sgn;
        logic [SW:0]    c_rem [3];
        logic [QW-1:0]  c_lo  [3];

        if (k == 0) begin : g_first
            assign c_v    = r_pp_v;
            assign c_dv   = r_pp_dv;
            assign c_half = r_pp_half;
            assign c_meta = r_pp_meta;
            assign c_ovf  = r_pp_ovf;
            assign c_sgn  = r_pp_sgn;
            assign c_rem  = r_pp_rem;
            assign c_lo   = r_pp_lo;
        end else begin : g_next
            assign c_v    = r_dv_v[k-1];
            assign c_dv   = r_dv_dv[k-1];
            assign c_half = r_dv_half[k-1];
            assign c_meta = r_dv_meta[k-1];
            assign c_ovf  = r_dv_ovf[k-1];
            assign c_sgn  = r_dv_sgn[k-1];
            assign c_rem  = r_dv_rem[k-1];
            assign c_lo   = r_dv_lo[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[k] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_dv[k]   <= c_dv;
                r_dv_half[k] <= c_half;
                r_dv_meta[k] <= c_meta;
                r_dv_ovf[k]  <= c_ovf;
                r_dv_sgn[k]  <= c_sgn;
            end
        end

        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic [SW+1:0] c_r2, c_sub;
            logic          c_ge;

            assign c_r2  = {c_rem[j], c_lo[j][QW-1]};
            assign c_ge  = (c_r2 >= (SW+2)'(c_dv));
            assign c_sub = c_r2 - (SW+2)'(c_dv);

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dv_rem[k][j] <= c_ge ? c_sub[SW:0] : c_r2[SW:0];
                    r_dv_lo[k][j]  <= {c_lo[j][QW-2:0], c_ge};
                end
            end
        end
    end

    // clamp to unit range, apply signs, place the dominant component, zero invalid words
    logic [FRAC_BITS:0]   w_one;
    logic [FRAC_BITS:0]   w_hmag;
    logic [ENTRY_W-1:0]   w_hv;
    logic [ENTRY_W-1:0]   w_lv [3];
    logic [ENTRY_W-1:0]   n_w, n_x, n_y, n_z;
    t_meta                w_meta;

    assign w_one  = {1'b1, {FRAC_BITS{1'b0}}};
    assign w_meta = r_dv_meta[QW-1];
    assign w_hmag = (r_dv_half[QW-1] > SW'(w_one)) ? w_one
                                                     : r_dv_half[QW-1][FRAC_BITS:0];
    assign w_hv   = ENTRY_W'(VW'(w_hmag));

    always_comb begin
        logic [QW-1:0]        v_q;
        logic [FRAC_BITS:0]   v_mag;
        logic signed [VW-1:0] v_val;
        for (int j = 0; j < 3; j++) begin
            v_q   = r_dv_lo[QW-1][j];
            v_mag = (r_dv_ovf[QW-1][j] || (v_q > QW'(w_one))) ? w_one : v_q[FRAC_BITS:0];
            v_val = r_dv_sgn[QW-1][j] ? -VW'(v_mag) : VW'(v_mag);
            w_lv[j] = v_val[ENTRY_W-1:0];
        end
    end

    always_comb begin
        case (w_meta.branch)
            BR_TRACE: begin
                n_w = w_hv;    n_x = w_lv[0]; n_y = w_lv[1]; n_z = w_lv[2];
            end
            BR_X: begin
                n_x = w_hv;    n_y = w_lv[0]; n_z = w_lv[1]; n_w = w_lv[2];
            end
            BR_Y: begin
                n_y = w_hv;    n_x = w_lv[0]; n_z = w_lv[1]; n_w = w_lv[2];
            end
            default: begin
                n_z = w_hv;    n_x = w_lv[0]; n_y = w_lv[1]; n_w = w_lv[2];
            end
        endcase
        if (w_meta.bad) begin
            n_w = '0;
            n_x = '0;
            n_y = '0;
            n_z = '0;
        end
    end

    // output register
    logic [ENTRY_W-1:0] r_o_w, r_o_x, r_o_y, r_o_z;
    logic [1:0]         r_o_branch;
    logic               r_o_invalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= r_dv_v[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_w       <= n_w;
            r_o_x       <= n_x;
            r_o_y       <= n_y;
            r_o_z       <= n_z;
            r_o_branch  <= w_meta.branch;
            r_o_invalid <= w_meta.bad;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_quat_w       = r_o_w;
    assign o_quat_x       = r_o_x;
    assign o_quat_y       = r_o_y;
    assign o_quat_z       = r_o_z;
    assign o_branch_taken = r_o_branch;
    assign o_invalid      = r_o_invalid;

    `RMQ_ASSERT_SAME(a_bad_zero, r_o_valid && r_o_invalid, (r_o_w == '0) && (r_o_x == '0) && (r_o_y == '0) && (r_o_z == '0))
    `RMQ_ASSERT_NEXT(a_pipe_hold, !w_en && r_dv_v[QW-1], r_dv_v[QW-1])

endmodule

`default_nettype wire

@@ sv/rotation_matrix_to_quaternion.sv @@
// path: front register, queue, one square root stage per root bit, divider setup,
//   one divider stage per quotient bit, output register
// throughput: one matrix word per cycle unless the output word is held by i_ready,
//   every square root and divider stage is pipelined
// reset: synchronous active low, clears valid bits, queue pointers and fill count only
// top level of the matrix to quaternion converter, depends on rmq_pkg and submodules
`default_nettype none

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [rmq_pkg::ENTRY_W-1:0] i_e00,
    input  logic signed [rmq_pkg::ENTRY_W-1:0] i_e01,
    input  logic signed [rmq_pkg::ENTRY_W-1:0] i_e02,
    input  logic signed [rmq_pkg::ENTRY_W-1:0] i_e10,
    input  logic signed [rmq_pkg::ENTRY_W-1:0] i_e11,
    input  logic signed [rmq_pkg::ENTRY_W-1:0] i_e12,
    input  logic signed [rmq_pkg::ENTRY_W-1:0] i_e20,
    input  logic signed [rmq_pkg::ENTRY_W-1:0] i_e21,
    input  logic signed [rmq_pkg::ENTRY_W-1:0] i_e22,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [rmq_pkg::ENTRY_W-1:0] o_quat_w,
    output logic signed [rmq_pkg::ENTRY_W-1:0] o_quat_x,
    output logic signed [rmq_pkg::ENTRY_W-1:0] o_quat_y,
    output logic signed [rmq_pkg::ENTRY_W-1:0] o_quat_z,
    output logic [1:0]                         o_branch_taken,
    output logic                               o_invalid
);
    import rmq_pkg::*;

    localparam int IW = f_item_w(FRAC_BITS);

    logic          w_f_valid, w_f_ready, w_q_valid, w_q_ready;
    logic [IW-1:0] w_f_item, w_q_item;

    // classify and form arguments
    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_e00        (i_e00),
        .i_e01        (i_e01),
        .i_e02        (i_e02),
        .i_e10        (i_e10),
        .i_e11        (i_e11),
        .i_e12        (i_e12),
        .i_e20        (i_e20),
        .i_e21        (i_e21),
        .i_e22        (i_e22),
        .o_item_valid (w_f_valid),
        .i_item_ready (w_f_ready),
        .o_item       (w_f_item)
    );

    // decoupling queue
    rmq_queue #(.WIDTH(IW), .DEPTH(Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_item),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_item)
    );

    // root, divide, saturate
    rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .o_ready        (w_q_ready),
        .i_item         (w_q_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_quat_w       (o_quat_w),
        .o_quat_x       (o_quat_x),
        .o_quat_y       (o_quat_y),
        .o_quat_z       (o_quat_z),
        .o_branch_taken (o_branch_taken),
        .o_invalid      (o_invalid)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for the rotation matrix to quaternion converter
// drives directed rows, then matrix words in random bursts, and checks each quaternion word against a predictor
// depends on rmq_pkg and rotation_matrix_to_quaternion
`timescale 1ns / 1ps

module tb;

    import rmq_pkg::*;

    localparam int FB        = 14;
    localparam int ONE       = 1 << FB;
    localparam int LATENCY   = 40;
    localparam int N_RANDOM  = 1700;
    localparam int CYCLE_MAX = 400000;

    typedef logic signed [15:0] t_entry;

    typedef struct {
        t_entry     e [9];
        logic [15:0] qw, qx, qy, qz;
        logic [1:0] br;
        logic       bad;
        logic       known;
    } t_row;

    typedef struct {
        logic [15:0] qw, qx, qy, qz;
        logic [1:0]  br;
        logic        bad;
    } t_quat;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_ready;
    t_entry i_e [9];
    logic   o_valid;
    logic   i_ready = 1'b0;
    t_entry o_quat_w, o_quat_x, o_quat_y, o_quat_z;
    logic [1:0] o_branch_taken;
    logic   o_invalid;

    t_quat  expected_quats [$];
    int     n_errors = 0;
    int     n_checked = 0;
    int     cycle = 0;
    bit     hold_off = 1'b0;
    int     branch_seen [4];
    int     n_invalid = 0;

    initial begin
        for (int k = 0; k < 9; k++) i_e[k] = '0;
    end

    rotation_matrix_to_quaternion #(.FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_e00(i_e[0]), .i_e01(i_e[1]), .i_e02(i_e[2]),
        .i_e10(i_e[3]), .i_e11(i_e[4]), .i_e12(i_e[5]),
        .i_e20(i_e[6]), .i_e21(i_e[7]), .i_e22(i_e[8]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_quat_w(o_quat_w), .o_quat_x(o_quat_x), .o_quat_y(o_quat_y),
        .o_quat_z(o_quat_z), .o_branch_taken(o_branch_taken), .o_invalid(o_invalid)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_MAX) begin
            $display("timeout with %0d words outstanding", expected_quats.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint sat_unit(input longint v);
        if (v > ONE) return ONE;
        if (v < -ONE) return -ONE;
        return v;
    endfunction

    // off-diagonal numerator over 2s, rounded half away from zero
    function automatic longint half_ratio(input longint d, input longint unsigned s);
        longint unsigned mag, q;
        if (s == 0) return 0;
        mag = (d < 0) ? -d : d;
        q = ((mag << FB) + s) / (s << 1);
        return sat_unit(d < 0 ? -longint'(q) : longint'(q));
    endfunction

    // shepperd conversion of one matrix word
    function automatic t_quat matrix_to_quat(input t_entry e [9]);
        t_quat r;
        longint m [9];
        longint tr, arg, half, w, x, y, z;
        longint unsigned s;
        for (int k = 0; k < 9; k++) m[k] = e[k];
        w = 0; x = 0; y = 0; z = 0;
        tr = m[0] + m[4] + m[8];
        if (tr > 0) begin
            r.br = BR_TRACE; arg = ONE + tr;
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            r.br = BR_X; arg = ONE + m[0] - m[4] - m[8];
        end else if (m[4] > m[8]) begin
            r.br = BR_Y; arg = ONE + m[4] - m[0] - m[8];
        end else begin
            r.br = BR_Z; arg = ONE + m[8] - m[0] - m[4];
        end
        r.bad = (arg <= 0);
        if (!r.bad) begin
            s = int_sqrt(longint'(arg) << FB);
            half = sat_unit((s + 1) >> 1);
            case (r.br)
                BR_TRACE: begin
                    w = half;
                    x = half_ratio(m[7] - m[5], s);
                    y = half_ratio(m[2] - m[6], s);
                    z = half_ratio(m[3] - m[1], s);
                end
                BR_X: begin
                    x = half;
                    y = half_ratio(m[1] + m[3], s);
                    z = half_ratio(m[6] + m[2], s);
                    w = half_ratio(m[7] - m[5], s);
                end
                BR_Y: begin
                    x = half_ratio(m[1] + m[3], s);
                    y = half;
                    z = half_ratio(m[5] + m[7], s);
                    w = half_ratio(m[2] - m[6], s);
                end
                default: begin
                    x = half_ratio(m[2] + m[6], s);
                    y = half_ratio(m[5] + m[7], s);
                    z = half;
                    w = half_ratio(m[3] - m[1], s);
                end
            endcase
        end
        r.qw = w[15:0]; r.qx = x[15:0]; r.qy = y[15:0]; r.qz = z[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= 30)
            $display("mismatch %s at word %0d: got %0h want %0h", what, n_checked, got, want);
    endtask

    // receiver: own stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            i_ready <= 1'b0;
        else if ((cycle / 64) % 3 == 0)
            i_ready <= 1'b1;
        else
            i_ready <= ($urandom_range(0, 3) != 0);
    end

    // output checking
    always @(posedge i_clk) begin
        t_quat w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_quats.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                w = expected_quats.pop_front();
                if (o_quat_w !== w.qw) report_mismatch("quat_w", o_quat_w, w.qw);
                if (o_quat_x !== w.qx) report_mismatch("quat_x", o_quat_x, w.qx);
                if (o_quat_y !== w.qy) report_mismatch("quat_y", o_quat_y, w.qy);
                if (o_quat_z !== w.qz) report_mismatch("quat_z", o_quat_z, w.qz);
                if (o_branch_taken !== w.br)
                    report_mismatch("branch_taken", o_branch_taken, w.br);
                if (o_invalid !== w.bad) report_mismatch("invalid", o_invalid, w.bad);
            end
            n_checked++;
        end
    end

    // offer one word and wait for it to be taken
    task automatic send_matrix(input t_entry e [9], input t_quat want);
        i_valid <= 1'b1;
        for (int k = 0; k < 9; k++) i_e[k] <= e[k];
        do @(posedge i_clk); while (!o_ready);
        expected_quats.push_back(want);
        branch_seen[want.br]++;
        if (want.bad) n_invalid++;
    endtask

    function automatic t_entry rand_entry();
        case ($urandom_range(0, 9))
            0:       return t_entry'($urandom);
            1:       return ($urandom_range(0, 1)) ? t_entry'(ONE) : t_entry'(-ONE);
            2:       return t_entry'(int'($urandom_range(0, 40)) - 20);
            default: return t_entry'(int'($urandom_range(0, 2 * ONE)) - ONE);
        endcase
    endfunction

    // near-rotation from a random unit-ish quaternion
    function automatic void rand_rotation(output t_entry e [9]);
        real a, b, c, d, n;
        a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
        c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
        n = a * a + b * b + c * c + d * d + 1.0;
        e[0] = t_entry'($rtoi(ONE * (a*a + b*b - c*c - d*d) / n));
        e[1] = t_entry'($rtoi(ONE * 2.0 * (b*c - a*d) / n));
        e[2] = t_entry'($rtoi(ONE * 2.0 * (b*d + a*c) / n));
        e[3] = t_entry'($rtoi(ONE * 2.0 * (b*c + a*d) / n));
        e[4] = t_entry'($rtoi(ONE * (a*a - b*b + c*c - d*d) / n));
        e[5] = t_entry'($rtoi(ONE * 2.0 * (c*d - a*b) / n));
        e[6] = t_entry'($rtoi(ONE * 2.0 * (b*d - a*c) / n));
        e[7] = t_entry'($rtoi(ONE * 2.0 * (c*d + a*b) / n));
        e[8] = t_entry'($rtoi(ONE * (a*a - b*b - c*c + d*d) / n));
    endfunction

    // stimulus
    initial begin
        t_row   rows [$];
        t_row   r;
        t_entry e [9];
        t_quat  want;
        int     burst, wait_cycles;

        // directed rows: identity, half turns, ties, negative diagonals, extremes
        r.known = 1'b1;
        r.e = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
        r.qw = ONE; r.qx = 0; r.qy = 0; r.qz = 0; r.br = BR_TRACE; r.bad = 0;
        rows.push_back(r);
        r.e = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
        r.qw = 0; r.qx = ONE; r.qy = 0; r.qz = 0; r.br = BR_X; rows.push_back(r);
        r.e = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};
        r.qx = 0; r.qy = ONE; r.br = BR_Y; rows.push_back(r);
        r.e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};
        r.qy = 0; r.qz = ONE; r.br = BR_Z; rows.push_back(r);
        // all-equal diagonal with zero trace falls to the last branch
        r.e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        r.qz = ONE / 2; r.br = BR_Z; rows.push_back(r);
        // all-negative diagonals also fall to the last branch, root stays positive
        r.known = 1'b0;
        r.e = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};
        rows.push_back(r);
        r.e = '{-16'sh8000, 0, 0, 0, -16'sh8000, 0, 0, 0, -16'sh8000};
        rows.push_back(r);
        r.e = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        rows.push_back(r);
        r.e = '{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000, 0,
                16'sh7fff, -16'sh8000, -16'sh8000, 0};
        rows.push_back(r);
        r.e = '{0, ONE, 0, -ONE, 0, 0, 0, 0, ONE};
        rows.push_back(r);
        r.e = '{0, -ONE, 0, ONE, -ONE, 0, 0, 0, ONE};
        rows.push_back(r);
        r.e = '{1, 0, 0, 0, 0, 0, 0, 0, -1};
        rows.push_back(r);
        r.e = '{-ONE, 16'sh7fff, -16'sh8000, 16'sh7fff, -ONE, 16'sh7fff,
                -16'sh8000, 16'sh7fff, -ONE + 1};
        rows.push_back(r);
        r.e = '{-ONE, -16'sh8000, 16'sh7fff, -16'sh8000, ONE - 1, -16'sh8000,
                16'sh7fff, 16'sh5555, ONE - 1};
        rows.push_back(r);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            want = matrix_to_quat(rows[k].e);
            if (rows[k].known) begin
                want.qw = rows[k].qw; want.qx = rows[k].qx; want.qy = rows[k].qy;
                want.qz = rows[k].qz; want.br = rows[k].br; want.bad = rows[k].bad;
            end
            send_matrix(rows[k].e, want);
        end

        // random part in bursts with gaps; one long receiver hold-off partway
        for (int n = 0; n < N_RANDOM; ) begin
            if (n >= 300 && n < 320 && !hold_off) begin
                hold_off <= 1'b1;
                fork
                    begin
                        repeat (300) @(posedge i_clk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                if ($urandom_range(0, 9) < 6) begin
                    rand_rotation(e);
                end else begin
                    for (int k = 0; k < 9; k++) e[k] = rand_entry();
                end
                send_matrix(e, matrix_to_quat(e));
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (wait_cycles > 0) begin
                i_valid <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (expected_quats.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);

        $display("checked %0d quaternion words: branches %0d/%0d/%0d/%0d, %0d invalid roots",
                 n_checked, branch_seen[0], branch_seen[1], branch_seen[2],
                 branch_seen[3], n_invalid);
        $display("mixed rotations and raw entries, bursty input, one long output stall");
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
